// ===== hw/rtl/rra_pkg.sv =====
// Shared types, constants and helpers for the register run allocator.
`default_nettype none

package rra_pkg;

    localparam int NUM_REGS   = 64;
    localparam int MAX_WIDTH  = 4;
    localparam int ALIGN_UNIT = 2;

    localparam int MODE_W  = 2;
    localparam int WIDTH_W = 3;
    localparam int IDX_W   = 6;
    localparam int MASK_W  = 64;
    // bitmap plus guard bits so a run starting at the top index never wraps
    localparam int EXT_W   = (1 << IDX_W) + MAX_WIDTH;

    localparam logic [MODE_W-1:0] MODE_START = 2'd0;
    localparam logic [MODE_W-1:0] MODE_USE   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DEF   = 2'd2;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [WIDTH_W-1:0] width;
        logic               is_fixed;
        logic [IDX_W-1:0]   reg_index;
    } req_t;

    typedef struct packed {
        logic [IDX_W-1:0] assigned_index;
        logic             found;
        logic             fixed_conflict;
    } rsp_t;

    typedef struct packed {
        logic capture;
        logic commit;
    } ctrl_cmd_t;

    function automatic logic [WIDTH_W-1:0] clamp_width(input logic [WIDTH_W-1:0] w);
        logic [WIDTH_W-1:0] res;
        res = w;
        if (w == '0) begin
            res = WIDTH_W'(1);
        end else if (w > WIDTH_W'(MAX_WIDTH)) begin
            res = WIDTH_W'(MAX_WIDTH);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/rra_ctrl.sv =====
// Controller: sequences capture and commit of one item and drives busy/done.
`default_nettype none

module rra_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    output logic                   done,
    output rra_pkg::ctrl_cmd_t     cmd
);

    typedef enum logic {
        IDLE,
        WORK
    } state_t;

    state_t state_reg, state_next;
    logic   done_reg, done_next;

    always_comb begin
        state_next  = state_reg;
        done_next   = 1'b0;
        cmd.capture = 1'b0;
        cmd.commit  = 1'b0;
        case (state_reg)
            IDLE: begin
                if (start) begin
                    cmd.capture = 1'b1;
                    state_next  = WORK;
                end
            end
            WORK: begin
                cmd.commit = 1'b1;
                done_next  = 1'b1;
                state_next = IDLE;
            end
            default: begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy = (state_reg == WORK);
    assign done = done_reg;

    a_capture_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |=> busy)
        else $error("accepted item did not enter work state");

    a_work_then_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> done)
        else $error("work cycle produced no result strobe");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_done_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while still busy");

endmodule

`default_nettype wire

// ===== hw/rtl/rra_datapath.sv =====
// Datapath: free bitmap, fit vector, priority search and result registers.
`default_nettype none

module rra_datapath (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire rra_pkg::ctrl_cmd_t           cmd,
    input  wire rra_pkg::req_t                request,
    input  wire logic                         cfg_we,
    input  wire logic [rra_pkg::MASK_W-1:0]   cfg_data,
    output rra_pkg::rsp_t                     result
);

    localparam int N  = rra_pkg::NUM_REGS;
    localparam int EW = rra_pkg::EXT_W;

    logic [rra_pkg::MASK_W-1:0]  mask_reg;
    logic [N-1:0]                free_map_reg, free_map_next;
    logic [N-1:0]                fits_reg, fits_next;
    logic [rra_pkg::MODE_W-1:0]  mode_reg;
    logic [rra_pkg::WIDTH_W-1:0] width_reg;
    logic                        fixed_reg;
    logic [rra_pkg::IDX_W-1:0]   base_reg;
    rra_pkg::rsp_t               result_reg, result_next;

    logic [EW-1:0]               free_ext;
    logic [rra_pkg::WIDTH_W-1:0] width_in;
    logic [rra_pkg::IDX_W-1:0]   enc_idx;
    logic                        any_fit;
    logic [rra_pkg::IDX_W-1:0]   run_pos;
    logic [EW-1:0]               low_ext;
    logic [EW-1:0]               run_ext;
    logic [N-1:0]                run_map;
    logic                        conflict;

    assign free_ext = {{(EW - N){1'b0}}, free_map_reg};
    assign width_in = rra_pkg::clamp_width(request.width);

    // fit vector for every start index, built from the item at capture
    always_comb begin
        logic ok;
        fits_next = '0;
        for (int s = 0; s < N; s++) begin
            ok = 1'b1;
            if (width_in > rra_pkg::WIDTH_W'(1) && (s % rra_pkg::ALIGN_UNIT) != 0) begin
                ok = 1'b0;
            end
            for (int i = 0; i < rra_pkg::MAX_WIDTH; i++) begin
                if (rra_pkg::WIDTH_W'(i) < width_in && !free_ext[s + i]) begin
                    ok = 1'b0;
                end
            end
            fits_next[s] = ok;
        end
    end

    // lowest fitting start
    always_comb begin
        enc_idx = '0;
        for (int s = N - 1; s >= 0; s--) begin
            if (fits_reg[s]) begin
                enc_idx = rra_pkg::IDX_W'(s);
            end
        end
    end

    assign any_fit = |fits_reg;
    assign run_pos = (mode_reg == rra_pkg::MODE_DEF && !fixed_reg) ? enc_idx : base_reg;

    always_comb begin
        low_ext = '0;
        for (int i = 0; i < rra_pkg::MAX_WIDTH; i++) begin
            low_ext[i] = (rra_pkg::WIDTH_W'(i) < width_reg);
        end
    end

    assign run_ext  = low_ext << run_pos;
    assign run_map  = run_ext[N-1:0];
    // registers beyond the bitmap count as busy
    assign conflict = |(run_ext & ~free_ext);

    always_comb begin
        free_map_next = free_map_reg;
        result_next   = '0;
        case (mode_reg)
            rra_pkg::MODE_START: begin
                free_map_next = mask_reg[N-1:0];
            end
            rra_pkg::MODE_USE: begin
                free_map_next = free_map_reg | run_map;
            end
            rra_pkg::MODE_DEF: begin
                if (fixed_reg) begin
                    free_map_next              = free_map_reg & ~run_map;
                    result_next.assigned_index = base_reg;
                    result_next.found          = 1'b1;
                    result_next.fixed_conflict = conflict;
                end else if (any_fit) begin
                    free_map_next              = free_map_reg & ~run_map;
                    result_next.assigned_index = enc_idx;
                    result_next.found          = 1'b1;
                end
            end
            default: begin
                free_map_next = free_map_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            mask_reg     <= '1;
            free_map_reg <= '0;
        end else begin
            if (cfg_we) begin
                mask_reg <= cfg_data;
            end
            if (cmd.commit) begin
                free_map_reg <= free_map_next;
            end
        end
    end

    // hold item fields and fit vector for the commit cycle
    always_ff @(posedge clk) begin
        if (cmd.capture) begin
            mode_reg  <= request.mode;
            width_reg <= width_in;
            fixed_reg <= request.is_fixed;
            base_reg  <= request.reg_index;
            fits_reg  <= fits_next;
        end
        if (cmd.commit) begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/register_run_allocator.sv =====
// Top level of the register run allocator.
//
// An item is accepted when start is high and busy is low; busy then stays high
// for one cycle, and the result appears with done high for exactly one cycle.
// A new item may be started in the same cycle that done is shown. At capture a
// fit vector for all start indices is registered from the free bitmap; in the
// work state it is priority-encoded and the bitmap is updated. Results cannot
// be held off; sample result whenever done is high. The allocatable mask is
// written through cfg_valid/cfg_data (cfg_ready is always high); the user must
// write it only while no item is in flight, which the block itself does not
// enforce. It takes effect at the next block start.
`default_nettype none

module register_run_allocator (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire rra_pkg::req_t               request,
    output logic                             done,
    output rra_pkg::rsp_t                    result,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [rra_pkg::MASK_W-1:0]  cfg_data
);

    rra_pkg::ctrl_cmd_t cmd;

    assign cfg_ready = 1'b1;

    rra_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    rra_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .request  (request),
        .cfg_we   (cfg_valid & cfg_ready),
        .cfg_data (cfg_data),
        .result   (result)
    );

endmodule

`default_nettype wire

// ===== dv/tb_register_run_allocator.sv =====
// Self-checking testbench for the register run allocator: bursty requests, mask reloads.
module tb_register_run_allocator;
    import rra_pkg::*;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam logic [MASK_W-1:0] MASK_ALL    = {MASK_W{1'b1}};
    localparam logic [MASK_W-1:0] MASK_NONE   = '0;
    localparam int                CFG_MASK    = 0;

    logic              clk;
    logic              rst_n;
    logic              start = 1'b0;
    logic              busy;
    req_t              request = '0;
    logic              done;
    rsp_t              result;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [MASK_W-1:0] cfg_data = '0;

    register_run_allocator u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    req_t              request_queue[$];
    rsp_t              expected_grants[$];
    logic [MASK_W-1:0] mask_shadow = MASK_ALL;
    logic [MASK_W-1:0] free_bits = '0;
    int                mismatches = 0;
    int                burst_left = 0;
    int                gap_left = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // Apply one item to the shadow bitmap and return the grant it should produce.
    function automatic rsp_t predict_grant(input req_t it);
        rsp_t g;
        int   w;
        int   base;
        bit   fits;
        g = '0;
        w = (it.width == 0) ? 1 : (it.width > MAX_WIDTH) ? MAX_WIDTH : int'(it.width);
        base = int'(it.reg_index);
        case (it.mode)
            MODE_START:
            begin
                free_bits = mask_shadow;
            end
            MODE_USE:
            begin
                for (int i = 0; i < w; i++)
                    if (base + i < NUM_REGS)
                        free_bits[base + i] = 1'b1;
            end
            MODE_DEF:
            begin
                if (it.is_fixed)
                begin
                    // out-of-range registers count as busy
                    for (int i = 0; i < w; i++)
                    begin
                        if (base + i >= NUM_REGS)
                            g.fixed_conflict = 1'b1;
                        else
                        begin
                            if (!free_bits[base + i])
                                g.fixed_conflict = 1'b1;
                            free_bits[base + i] = 1'b0;
                        end
                    end
                    g.assigned_index = it.reg_index;
                    g.found = 1'b1;
                end
                else
                begin
                    for (int s = 0; s + w <= NUM_REGS; s++)
                    begin
                        if (w > 1 && (s % ALIGN_UNIT) != 0)
                            continue;
                        fits = 1'b1;
                        for (int i = 0; i < w; i++)
                            if (!free_bits[s + i])
                                fits = 1'b0;
                        if (fits)
                        begin
                            for (int i = 0; i < w; i++)
                                free_bits[s + i] = 1'b0;
                            g.assigned_index = IDX_W'(s);
                            g.found = 1'b1;
                            break;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        return g;
    endfunction

    function automatic req_t make_item(input logic [MODE_W-1:0] mode, input int w,
                                       input bit fixed, input int idx);
        req_t it;
        it.mode = mode;
        it.width = WIDTH_W'(w);
        it.is_fixed = fixed;
        it.reg_index = IDX_W'(idx);
        return it;
    endfunction

    // Driver: hold the item until accepted, then advance or insert a gap.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            request <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else if (!start || !busy)
        begin
            if (gap_left > 0)
            begin
                start <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (request_queue.size() > 0)
            begin
                request <= request_queue.pop_front();
                start <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor: check the oldest grant first, then predict for a newly accepted item.
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                mask_shadow = cfg_data;
            if (done)
            begin
                if (expected_grants.size() == 0)
                begin
                    $error("result with no item outstanding: %p", result);
                    mismatches++;
                end
                else
                begin
                    want = expected_grants.pop_front();
                    if (result.assigned_index !== want.assigned_index)
                    begin
                        $error("assigned_index: expected %0d, got %0d",
                               want.assigned_index, result.assigned_index);
                        mismatches++;
                    end
                    if (result.found !== want.found)
                    begin
                        $error("found: expected %0b, got %0b", want.found, result.found);
                        mismatches++;
                    end
                    if (result.fixed_conflict !== want.fixed_conflict)
                    begin
                        $error("fixed_conflict: expected %0b, got %0b",
                               want.fixed_conflict, result.fixed_conflict);
                        mismatches++;
                    end
                end
            end
            if (start && !busy)
                expected_grants.push_back(predict_grant(request));
        end
    end

    task automatic load_mask(input logic [MASK_W-1:0] m);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= m;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (request_queue.size() > 0 || start || expected_grants.size() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        req_t              it;
        logic [MASK_W-1:0] m;
        int                r;
        int                w;

        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: full mask, widths 0 to 4 and 7, edge indices, unused mode
        load_mask(MASK_ALL);
        request_queue.push_back(make_item(MODE_START, 1, 0, 0));
        request_queue.push_back(make_item(MODE_DEF, 1, 0, 0));
        request_queue.push_back(make_item(MODE_DEF, 2, 0, 0));
        request_queue.push_back(make_item(MODE_DEF, 3, 0, 0));
        request_queue.push_back(make_item(MODE_DEF, 4, 0, 0));
        request_queue.push_back(make_item(MODE_DEF, 0, 0, 0));
        request_queue.push_back(make_item(MODE_DEF, 7, 0, 0));
        request_queue.push_back(make_item(MODE_DEF, 4, 1, 63));
        request_queue.push_back(make_item(MODE_DEF, 1, 1, 0));
        request_queue.push_back(make_item(MODE_USE, 4, 0, 62));
        request_queue.push_back(make_item(MODE_USE, 0, 1, 0));
        request_queue.push_back(make_item(MODE_UNUSED, 7, 1, 63));
        wait_idle();

        // empty mask: a search fails, a fixed claim conflicts, a search into freed registers succeeds
        load_mask(MASK_NONE);
        request_queue.push_back(make_item(MODE_START, 1, 0, 0));
        request_queue.push_back(make_item(MODE_DEF, 1, 0, 0));
        request_queue.push_back(make_item(MODE_DEF, 2, 1, 5));
        request_queue.push_back(make_item(MODE_USE, 3, 0, 10));
        request_queue.push_back(make_item(MODE_DEF, 3, 0, 0));
        wait_idle();

        // only the top four free: a width-4 run at start 60, then exhaustion and reuse
        load_mask({4'hF, 60'h0});
        request_queue.push_back(make_item(MODE_START, 1, 0, 0));
        request_queue.push_back(make_item(MODE_DEF, 4, 0, 0));
        request_queue.push_back(make_item(MODE_DEF, 1, 0, 0));
        request_queue.push_back(make_item(MODE_USE, 1, 0, 61));
        request_queue.push_back(make_item(MODE_DEF, 1, 0, 0));
        wait_idle();

        for (int ph = 0; ph < 8; ph++)
        begin
            case ($urandom_range(0, 3))
                0: m = {$urandom, $urandom};
                1: m = {$urandom, $urandom} & {$urandom, $urandom};
                2: m = {$urandom, $urandom} | {$urandom, $urandom};
                default: m = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
            endcase
            if (ph == 0)
                m = MASK_ALL;
            else if (ph == 7)
                m = {32'h5555_5555, 32'hAAAA_AAAA};
            load_mask(m);
            request_queue.push_back(make_item(MODE_START, $urandom_range(0, 7), 0, 0));
            for (int n = 0; n < 240; n++)
            begin
                r = $urandom_range(0, 99);
                // mostly legal widths; 5..7 saturate and 8 wraps to the zero encoding
                w = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4) : $urandom_range(5, 8);
                it = make_item(MODE_DEF, w, ($urandom_range(0, 3) == 0), $urandom_range(0, 63));
                if (r < 4)
                    it.mode = MODE_START;
                else if (r < 7)
                    it.mode = MODE_UNUSED;
                else if (r < 37)
                begin
                    it.mode = MODE_USE;
                    it.is_fixed = 1'($urandom_range(0, 1));
                end
                request_queue.push_back(it);
            end
            wait_idle();
        end

        repeat (10) @(posedge clk);
        if (expected_grants.size() != 0)
        begin
            $error("%0d results never arrived", expected_grants.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/rra_pkg.sv
hw/rtl/rra_ctrl.sv
hw/rtl/rra_datapath.sv
hw/rtl/register_run_allocator.sv
dv/tb_register_run_allocator.sv
